[design/apdfe_pkg.sv]
// shared types and constants for the ais payload de-armoring and field extract block
// no dependencies
`default_nettype none

package apdfe_pkg;

    localparam int MAX_PAYLOAD_BYTES = 128;
    localparam int ADDR_W = $clog2(MAX_PAYLOAD_BYTES);
    localparam int CNT_W  = $clog2(MAX_PAYLOAD_BYTES + 1);
    localparam int IDX_W  = (CNT_W > 8) ? CNT_W : 8;

    localparam int OFF_W     = 10;
    localparam int LEN_W     = 7;
    localparam int FIELD_W   = 64;
    localparam int WIN_BYTES = 9;
    localparam int WIN_W     = WIN_BYTES * 8;
    localparam int K_W       = $clog2(WIN_BYTES + 1);

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0]       CHAR_BIAS  = 8'd48;
    localparam logic [7:0]       CHAR_LIMIT = 8'd40;
    localparam logic [7:0]       CHAR_GAP   = 8'd8;
    localparam logic [7:0]       SIX_MASK   = 8'h3F;
    localparam logic [7:0]       BAD_MASK   = 8'hC0;
    localparam logic [LEN_W-1:0] LEN_MAX    = LEN_W'(FIELD_W);

    typedef enum logic {
        OP_CHAR = 1'b0,
        OP_READ = 1'b1
    } t_op;

    typedef struct packed {
        t_op              op;
        logic [7:0]       armored_char;
        logic             start_flag;
        logic [OFF_W-1:0] bit_offset;
        logic [LEN_W-1:0] bit_length;
        logic             sign_extend;
    } t_in_item;

    typedef struct packed {
        logic [FIELD_W-1:0] field_value;
        logic               beyond_end;
        logic               bad_char_seen;
    } t_out_item;

    // classified item as it travels from front to back
    typedef struct packed {
        t_op              op;
        logic             start;
        logic [5:0]       six;
        logic             bad;
        logic [OFF_W-1:0] off;
        logic [LEN_W-1:0] len;
        logic [7:0]       last_idx;
        logic             sx;
    } t_cmd;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_SHIFT,
        S_MASK
    } t_state;

endpackage

`default_nettype wire

[design/ais_payload_dearmor_field_extract_core.sv]
// Armored AIS payload characters are decoded to six bits and packed MSB-first into a
// byte store of MAX_PAYLOAD_BYTES entries; read beats return a field of up to 64 bits,
// zero- or sign-extended, with flags for reads past the stored bytes and for bad
// characters. A character beat is handled by the back end while it is idle; a read
// beat walks nine bytes through the single byte-wide read port of the payload store
// and then runs the shift and mask steps. A front register and a two-entry queue let
// new beats be taken while the back end works or a result waits. Reset needs no
// clearing pass. Depends on apdfe_pkg, apdfe_front, apdfe_queue, apdfe_back.
`default_nettype none

module ais_payload_dearmor_field_extract_core
    import apdfe_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_valid,
    output logic          o_ready,
    input  wire t_in_item i_data,
    output logic          o_valid,
    input  wire logic     i_ready,
    output t_out_item     o_data
);

    logic f_valid;
    logic q_in_ready;
    t_cmd f_cmd;
    logic q_valid;
    logic q_pop;
    t_cmd q_cmd;

    apdfe_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_data      (i_data),
        .o_cmd_valid (f_valid),
        .i_cmd_ready (q_in_ready),
        .o_cmd       (f_cmd)
    );

    apdfe_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_valid),
        .o_ready (q_in_ready),
        .i_cmd   (f_cmd),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_cmd   (q_cmd)
    );

    apdfe_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (q_valid),
        .i_cmd       (q_cmd),
        .o_cmd_pop   (q_pop),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_data      (o_data)
    );

endmodule

`default_nettype wire

[design/apdfe_front.sv]
// front end: accepts input beats, decodes characters and prepares read requests
// depends on apdfe_pkg
`default_nettype none

module apdfe_front
    import apdfe_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_valid,
    output logic          o_ready,
    input  wire t_in_item i_data,
    output logic          o_cmd_valid,
    input  wire logic     i_cmd_ready,
    output t_cmd          o_cmd
);

    logic             r_valid;
    t_cmd             r_cmd;
    t_cmd             n_cmd;
    logic [7:0]       c0;
    logic [7:0]       c1;
    logic [LEN_W-1:0] len_sat;
    logic [OFF_W:0]   last_bit;
    logic             take;

    always_comb begin
        c0 = i_data.armored_char - CHAR_BIAS;
        c1 = (c0 > CHAR_LIMIT) ? (c0 - CHAR_GAP) : c0;
        len_sat = (i_data.bit_length > LEN_MAX) ? LEN_MAX : i_data.bit_length;
        last_bit = {1'b0, i_data.bit_offset} + (OFF_W + 1)'(len_sat) - (OFF_W + 1)'(1);

        n_cmd.op       = i_data.op;
        n_cmd.start    = i_data.start_flag;
        n_cmd.six      = 6'(c1 & SIX_MASK);
        n_cmd.bad      = |(c1 & BAD_MASK);
        n_cmd.off      = i_data.bit_offset;
        n_cmd.len      = len_sat;
        n_cmd.last_idx = 8'(last_bit >> 3);
        n_cmd.sx       = i_data.sign_extend;
    end

    assign o_ready     = !r_valid || i_cmd_ready;
    assign take        = i_valid && o_ready;
    assign o_cmd_valid = r_valid;
    assign o_cmd       = r_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (take) begin
            r_valid <= 1'b1;
        end else if (i_cmd_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_cmd <= n_cmd;
        end
    end

endmodule

`default_nettype wire

[design/apdfe_queue.sv]
// short command queue between front and back end
// depends on apdfe_pkg
`default_nettype none

module apdfe_queue
    import apdfe_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    output logic      o_ready,
    input  wire t_cmd i_cmd,
    output logic      o_valid,
    input  wire logic i_pop,
    output t_cmd      o_cmd
);

    t_cmd              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wptr;
    logic [QPTR_W-1:0] r_rptr;
    logic [QCNT_W-1:0] r_cnt;
    logic              do_push;
    logic              do_pop;

    assign o_ready = (r_cnt != QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_mem[r_rptr];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= (r_wptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= (r_rptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

endmodule

`default_nettype wire

[design/apdfe_back.sv]
// back end: packs characters into the payload store and walks it for field reads
// depends on apdfe_pkg; holds the byte-wide payload memory and the result register
`default_nettype none

module apdfe_back
    import apdfe_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_cmd_valid,
    input  wire t_cmd  i_cmd,
    output logic       o_cmd_pop,
    output logic       o_valid,
    input  wire logic  i_ready,
    output t_out_item  o_data
);

    logic [7:0] mem [MAX_PAYLOAD_BYTES];

    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [1:0]         r_phase, n_phase;
    logic [7:0]         r_partial, n_partial;
    logic               r_bad, n_bad;
    logic [K_W-1:0]     r_k, n_k;
    logic [IDX_W-1:0]   r_idx, n_idx;
    logic [IDX_W-1:0]   r_last, n_last;
    logic [2:0]         r_off_lo, n_off_lo;
    logic [LEN_W-1:0]   r_len, n_len;
    logic               r_sx, n_sx;
    logic [WIN_W-1:0]   r_acc, n_acc;
    logic [FIELD_W-1:0] r_val, n_val;
    logic [7:0]         r_rd_data;
    logic               r_rd_ok;
    logic               r_out_valid, n_out_valid;
    t_out_item          r_out, n_out;

    logic [CNT_W-1:0]   base_count;
    logic [1:0]         base_phase;
    logic [7:0]         base_partial;
    logic               base_bad;
    logic               byte_done;
    logic [7:0]         wbyte;
    logic               mem_we;
    logic               mem_re;
    logic               rd_ok;
    logic [LEN_W-1:0]   sh;
    logic [FIELD_W-1:0] mask;
    logic               sign;
    logic               load_out;

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_phase     = r_phase;
        n_partial   = r_partial;
        n_bad       = r_bad;
        n_k         = r_k;
        n_idx       = r_idx;
        n_last      = r_last;
        n_off_lo    = r_off_lo;
        n_len       = r_len;
        n_sx        = r_sx;
        n_acc       = r_acc;
        n_val       = r_val;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        o_cmd_pop   = 1'b0;
        mem_we      = 1'b0;
        mem_re      = 1'b0;
        load_out    = 1'b0;
        byte_done   = 1'b0;
        wbyte       = 8'd0;
        sh          = '0;
        mask        = '0;
        sign        = 1'b0;

        // a character beat that starts a new payload drops everything held so far
        base_count   = i_cmd.start ? '0 : r_count;
        base_phase   = i_cmd.start ? 2'd0 : r_phase;
        base_partial = i_cmd.start ? 8'd0 : r_partial;
        base_bad     = i_cmd.start ? 1'b0 : r_bad;

        rd_ok = (r_idx < IDX_W'(r_count));

        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_pop = 1'b1;
                    if (i_cmd.op == OP_CHAR) begin
                        unique case (base_phase)
                            2'd0: begin
                                n_partial = {i_cmd.six, 2'b00};
                            end
                            2'd1: begin
                                byte_done = 1'b1;
                                wbyte     = base_partial | {6'd0, i_cmd.six[5:4]};
                                n_partial = {i_cmd.six[3:0], 4'd0};
                            end
                            2'd2: begin
                                byte_done = 1'b1;
                                wbyte     = base_partial | {4'd0, i_cmd.six[5:2]};
                                n_partial = {i_cmd.six[1:0], 6'd0};
                            end
                            default: begin
                                byte_done = 1'b1;
                                wbyte     = base_partial | {2'd0, i_cmd.six};
                                n_partial = 8'd0;
                            end
                        endcase
                        n_phase = base_phase + 2'd1;
                        n_bad   = base_bad | i_cmd.bad;
                        n_count = base_count;
                        // full store drops the byte, phase still moves on
                        if (byte_done && (base_count < CNT_W'(MAX_PAYLOAD_BYTES))) begin
                            mem_we  = 1'b1;
                            n_count = base_count + 1'b1;
                        end
                    end else begin
                        n_idx    = IDX_W'(i_cmd.off >> 3);
                        n_last   = IDX_W'(i_cmd.last_idx);
                        n_off_lo = i_cmd.off[2:0];
                        n_len    = i_cmd.len;
                        n_sx     = i_cmd.sx;
                        n_k      = '0;
                        n_state  = S_READ;
                    end
                end
            end
            S_READ: begin
                // each address is read into r_rd_data and shifted into the window in the next beat
                if (r_k != K_W'(WIN_BYTES)) begin
                    mem_re = 1'b1;
                    n_idx  = r_idx + 1'b1;
                end
                if (r_k != '0) begin
                    n_acc = {r_acc[WIN_W-9:0], r_rd_ok ? r_rd_data : 8'd0};
                end
                n_k = r_k + 1'b1;
                if (r_k == K_W'(WIN_BYTES)) begin
                    n_state = S_SHIFT;
                end
            end
            S_SHIFT: begin
                sh      = LEN_W'(WIN_W) - LEN_W'(r_off_lo) - r_len;
                n_val   = FIELD_W'(r_acc >> sh);
                n_state = S_MASK;
            end
            S_MASK: begin
                mask = (r_len == LEN_MAX) ? '1
                     : ((FIELD_W'(1) << r_len) - FIELD_W'(1));
                if (r_sx && (r_len != '0) && (r_len != LEN_MAX)) begin
                    sign = r_val[r_len[5:0] - 6'd1];
                end
                if (!r_out_valid || i_ready) begin
                    load_out                = 1'b1;
                    n_out_valid             = 1'b1;
                    n_out.field_value       = (r_val & mask) | (sign ? ~mask : '0);
                    n_out.beyond_end        = (r_len != '0) && (r_last >= IDX_W'(r_count));
                    n_out.bad_char_seen     = r_bad;
                    n_state                 = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_phase     <= 2'd0;
            r_partial   <= 8'd0;
            r_bad       <= 1'b0;
            r_k         <= '0;
            r_rd_ok     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_phase     <= n_phase;
            r_partial   <= n_partial;
            r_bad       <= n_bad;
            r_k         <= n_k;
            r_out_valid <= n_out_valid;
            if (mem_re) begin
                r_rd_ok <= rd_ok;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_last   <= n_last;
        r_off_lo <= n_off_lo;
        r_len    <= n_len;
        r_sx     <= n_sx;
        r_acc    <= n_acc;
        r_val    <= n_val;
        if (load_out) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[base_count[ADDR_W-1:0]] <= wbyte;
        end
        if (mem_re) begin
            r_rd_data <= mem[r_idx[ADDR_W-1:0]];
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule

`default_nettype wire

[design/apdfe_checker.sv]
// port-level checks for the ais payload de-armoring core, bound to the top level
// depends on apdfe_pkg and ais_payload_dearmor_field_extract_core
`default_nettype none

module apdfe_checker
    import apdfe_pkg::*;
(
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      i_valid,
    input wire logic      o_ready,
    input wire t_in_item  i_data,
    input wire logic      o_valid,
    input wire logic      i_ready,
    input wire t_out_item o_data
);

    // no result right after reset
    a_reset_quiet: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_data))
        else $error("stalled result changed");

    // handshake outputs are always driven once out of reset
    a_handshake_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$isunknown({o_valid, o_ready}))
        else $error("handshake output unknown");

    // a result only rises once reset has been released
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(i_rst_n))
        else $error("result out of reset");

endmodule

bind ais_payload_dearmor_field_extract_core apdfe_checker u_apdfe_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .o_ready (o_ready),
    .i_data  (i_data),
    .o_valid (o_valid),
    .i_ready (i_ready),
    .o_data  (o_data)
);

`default_nettype wire
